// ----- sv/rpwf_pkg.sv -----
// ----------------------------------------------------------------------------
// rpwf_pkg
// Shared types, register codes and a helper function for the rotated
// pixel write formatter.
// ----------------------------------------------------------------------------
package rpwf_pkg;

    // Host byte order used when packing 16, 24 and 32 bpp words.
    localparam int BIG_ENDIAN_HOST_DEFAULT = 0;

    localparam int COORD_W   = 12;  // view coordinates after clipping
    localparam int PROD_W    = 28;  // row * line_stride
    localparam int COLOFS_W  = 14;  // column * bytes per pixel
    localparam int IN_DATA_W = 56;
    localparam int OUT_DATA_W = 72;

    // Rotation codes.
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // Color order codes; any code with bit 1 set selects the generic layout.
    localparam logic [1:0] ORDER_RGB     = 2'd0;
    localparam logic [1:0] ORDER_BGR     = 2'd1;
    localparam logic [1:0] ORDER_GENERIC = 2'd2;

    // Pixel depth codes.
    localparam logic [1:0] DEPTH_16   = 2'd0;
    localparam logic [1:0] DEPTH_24   = 2'd1;
    localparam logic [1:0] DEPTH_32   = 2'd2;
    localparam logic [1:0] DEPTH_NONE = 2'd3;

    // Bytes per pixel.
    localparam logic [2:0] BYTES_16 = 3'd2;
    localparam logic [2:0] BYTES_24 = 3'd3;
    localparam logic [2:0] BYTES_32 = 3'd4;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_ROTATION       = 3'd0,
        CFG_COLOR_ORDER    = 3'd1,
        CFG_PIXEL_DEPTH    = 3'd2,
        CFG_LINE_STRIDE    = 3'd3,
        CFG_VIEW_WIDTH     = 3'd4,
        CFG_VIEW_HEIGHT    = 3'd5,
        CFG_CHANNEL_LAYOUT = 3'd6,
        CFG_BUFFER_BASE    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]  rotation;
        logic [1:0]  color_order;
        logic [1:0]  pixel_depth;
        logic [15:0] line_stride;
        logic [11:0] view_width;
        logic [11:0] view_height;
        logic [26:0] channel_layout;
        logic [31:0] buffer_base;
    } cfg_t;

    // Contents of the clip and rotate stage register.
    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [2:0]         bytes;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } s1_t;

    // One channel of the generic layout: keep the top len bits (at most 8)
    // and place them at the given offset within a 32-bit word.
    function automatic logic [31:0] chan_generic(input logic [7:0] c,
                                                 input logic [8:0] group);
        logic [3:0] len;
        logic [7:0] v;
        len = (group[8:5] > 4'd8) ? 4'd8 : group[8:5];
        v   = c >> (4'd8 - len);
        return {24'd0, v} << group[4:0];
    endfunction

endpackage

// ----- sv/rpwf_clip_rot.sv -----
// ----------------------------------------------------------------------------
// rpwf_clip_rot
// First pipeline stage: drops pixels outside the view or with no valid
// format, rotates the position and registers column, row, pixel size and color.
// ----------------------------------------------------------------------------
module rpwf_clip_rot (
    input  logic          clk,
    input  logic          rst_n,
    input  rpwf_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [15:0]   pos_x,
    input  logic [15:0]   pos_y,
    input  logic [7:0]    red,
    input  logic [7:0]    green,
    input  logic [7:0]    blue,
    input  logic          out_ready,
    output rpwf_pkg::s1_t out
);
    import rpwf_pkg::*;

    s1_t              s1_reg;
    s1_t              s1_next;
    logic             keep;
    logic             x_in;
    logic             y_in;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x_mirror;
    logic [COORD_W-1:0] y_mirror;

    assign in_ready = !s1_reg.valid || out_ready;

    // A negative position has its sign bit set and never lies in the view.
    assign x_in = !pos_x[15] && ({1'b0, pos_x[14:0]} < {4'd0, cfg.view_width});
    assign y_in = !pos_y[15] && ({1'b0, pos_y[14:0]} < {4'd0, cfg.view_height});
    assign x    = pos_x[COORD_W-1:0];
    assign y    = pos_y[COORD_W-1:0];
    assign x_mirror = cfg.view_width - x - 12'd1;
    assign y_mirror = cfg.view_height - y - 12'd1;

    // Generic layout has no 24 bpp form, and the unsupported depth writes nothing.
    assign keep = x_in && y_in && (cfg.pixel_depth != DEPTH_NONE)
                  && !(cfg.color_order[1] && (cfg.pixel_depth == DEPTH_24));

    always_comb
    begin
        s1_next       = s1_reg;
        s1_next.valid = in_valid && keep;
        s1_next.red   = red;
        s1_next.green = green;
        s1_next.blue  = blue;
        case (cfg.rotation)
            ROT_90:
            begin
                s1_next.col = y_mirror;
                s1_next.row = x;
            end
            ROT_180:
            begin
                s1_next.col = x_mirror;
                s1_next.row = y_mirror;
            end
            ROT_270:
            begin
                s1_next.col = y;
                s1_next.row = x_mirror;
            end
            default:
            begin
                s1_next.col = x;
                s1_next.row = y;
            end
        endcase
        case (cfg.pixel_depth)
            DEPTH_16: s1_next.bytes = BYTES_16;
            DEPTH_24: s1_next.bytes = BYTES_24;
            default:  s1_next.bytes = BYTES_32;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else if (in_ready)
        begin
            s1_reg <= s1_next;
        end
    end

    assign out = s1_reg;

endmodule

// ----- sv/rpwf_pack.sv -----
// ----------------------------------------------------------------------------
// rpwf_pack
// Color packer: forms the memory word for RGB, BGR or the generic channel
// layout at the configured depth, in host byte order.
// ----------------------------------------------------------------------------
module rpwf_pack #(
    parameter int BIG_ENDIAN_HOST = rpwf_pkg::BIG_ENDIAN_HOST_DEFAULT
) (
    input  logic [1:0]  color_order,
    input  logic [1:0]  pixel_depth,
    input  logic [26:0] channel_layout,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic [31:0] data
);
    import rpwf_pkg::*;

    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [31:0] word;
    logic [31:0] generic_word;

    assign hi = (color_order == ORDER_RGB) ? red : blue;
    assign lo = (color_order == ORDER_RGB) ? blue : red;

    assign generic_word = chan_generic(red,   channel_layout[8:0])
                        | chan_generic(green, channel_layout[17:9])
                        | chan_generic(blue,  channel_layout[26:18]);

    always_comb
    begin
        word = 32'd0;
        case (pixel_depth)
            DEPTH_16:
            begin
                if (color_order[1])
                    word = {16'd0, generic_word[15:0]};
                else
                    word = {16'd0, hi[7:3], green[7:2], lo[7:3]};
                if (BIG_ENDIAN_HOST != 0)
                    word = {16'd0, word[7:0], word[15:8]};
            end
            DEPTH_24:
            begin
                // Three bytes; a big-endian host gets them in reversed byte order.
                if (BIG_ENDIAN_HOST != 0)
                    word = {8'd0, lo, green, hi};
                else
                    word = {8'd0, hi, green, lo};
            end
            default:
            begin
                if (color_order[1])
                    word = generic_word;
                else
                    word = {8'd0, hi, green, lo};
                if (BIG_ENDIAN_HOST != 0)
                    word = {word[7:0], word[15:8], word[23:16], word[31:24]};
            end
        endcase
    end

    assign data = word;

endmodule

// ----- sv/rotated_pixel_write_formatter_core.sv -----
// ----------------------------------------------------------------------------
// rotated_pixel_write_formatter_core
// Turns logical pixels into framebuffer memory writes with clipping,
// rotation, address generation and color packing.
// ----------------------------------------------------------------------------
// Usage:
// Pixels arrive on the s_ channel, one per transfer, and each pixel that
// falls inside the view leaves as one write on the m_ channel: byte
// address, packed data word (first byte in bits 7:0) and byte count.
// Pixels outside the view, pixels at the unsupported depth and generic
// layout pixels at 24 bpp cause no write; they leave a bubble only.
// The block takes one pixel per clock unless m_tready stalls it. A write
// passes three registered stages on its way to m_tvalid: clip and rotate,
// then row times stride with color packing, then the final address add.
// Every stage holds its valid bit; a stage loads when it is empty or
// when the stage after it moves, so a stalled m_tready fills the three
// stages and then drops s_tready, and no item is lost or repeated.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_data with no handshake and should only change while the pipeline
// is empty. Reset clears all stage valid bits and sets every register
// to zero except pixel_depth, which returns to 32 bpp.
// ----------------------------------------------------------------------------
module rotated_pixel_write_formatter_core #(
    parameter int BIG_ENDIAN_HOST = rpwf_pkg::BIG_ENDIAN_HOST_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // Pixel input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata fields, low bit up: pos_x[15:0], pos_y[31:16], red[39:32],
    // green[47:40], blue[55:48].
    input  logic [rpwf_pkg::IN_DATA_W-1:0]  s_tdata,
    // Memory write stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata fields, low bit up: write_address[31:0], write_data[63:32],
    // byte_count[66:64], zero fill [71:67].
    output logic [rpwf_pkg::OUT_DATA_W-1:0] m_tdata
);
    import rpwf_pkg::*;

    // Configuration registers.
    cfg_t cfg_reg;

    // Stage interconnect.
    s1_t  s1;
    logic s1_ready;

    // Second stage: partial address terms and packed data.
    logic                s2_valid_reg;
    logic [PROD_W-1:0]   s2_prod_reg;
    logic [PROD_W-1:0]   s2_prod_next;
    logic [COLOFS_W-1:0] s2_colofs_reg;
    logic [COLOFS_W-1:0] s2_colofs_next;
    logic [31:0]         s2_data_reg;
    logic [31:0]         s2_data_next;
    logic [2:0]          s2_bytes_reg;
    logic                s2_ready;
    logic [14:0]         colofs_full;

    // Output stage.
    logic        out_valid_reg;
    logic [31:0] out_addr_reg;
    logic [31:0] out_addr_next;
    logic [31:0] out_data_reg;
    logic [2:0]  out_bytes_reg;
    logic        out_ready;

    // ------------------------------------------------------------------------
    // Configuration writes. Values wider than a register are truncated.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rotation       <= ROT_0;
            cfg_reg.color_order    <= ORDER_RGB;
            cfg_reg.pixel_depth    <= DEPTH_32;
            cfg_reg.line_stride    <= 16'd0;
            cfg_reg.view_width     <= 12'd0;
            cfg_reg.view_height    <= 12'd0;
            cfg_reg.channel_layout <= 27'd0;
            cfg_reg.buffer_base    <= 32'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ROTATION:       cfg_reg.rotation       <= cfg_data[1:0];
                CFG_COLOR_ORDER:    cfg_reg.color_order    <= cfg_data[1:0];
                CFG_PIXEL_DEPTH:    cfg_reg.pixel_depth    <= cfg_data[1:0];
                CFG_LINE_STRIDE:    cfg_reg.line_stride    <= cfg_data[15:0];
                CFG_VIEW_WIDTH:     cfg_reg.view_width     <= cfg_data[11:0];
                CFG_VIEW_HEIGHT:    cfg_reg.view_height    <= cfg_data[11:0];
                CFG_CHANNEL_LAYOUT: cfg_reg.channel_layout <= cfg_data[26:0];
                CFG_BUFFER_BASE:    cfg_reg.buffer_base    <= cfg_data;
                default:            cfg_reg.buffer_base    <= cfg_reg.buffer_base;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Backpressure chain: a stage may load when it is empty or draining.
    // ------------------------------------------------------------------------
    assign out_ready = !out_valid_reg || m_tready;
    assign s2_ready  = !s2_valid_reg || out_ready;

    // ------------------------------------------------------------------------
    // Stage 1: clip and rotate.
    // ------------------------------------------------------------------------
    rpwf_clip_rot u_clip_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s1_ready),
        .pos_x     (s_tdata[15:0]),
        .pos_y     (s_tdata[31:16]),
        .red       (s_tdata[39:32]),
        .green     (s_tdata[47:40]),
        .blue      (s_tdata[55:48]),
        .out_ready (s2_ready),
        .out       (s1)
    );

    assign s_tready = s1_ready;

    // ------------------------------------------------------------------------
    // Stage 2: row times stride, column times pixel size, color packing.
    // The column offset stays below 4096 * 4, so 14 bits hold it.
    // ------------------------------------------------------------------------
    assign s2_prod_next   = PROD_W'(s1.row) * PROD_W'(cfg_reg.line_stride);
    assign colofs_full    = 15'(s1.col) * 15'(s1.bytes);
    assign s2_colofs_next = colofs_full[COLOFS_W-1:0];

    rpwf_pack #(
        .BIG_ENDIAN_HOST (BIG_ENDIAN_HOST)
    ) u_pack (
        .color_order    (cfg_reg.color_order),
        .pixel_depth    (cfg_reg.pixel_depth),
        .channel_layout (cfg_reg.channel_layout),
        .red            (s1.red),
        .green          (s1.green),
        .blue           (s1.blue),
        .data           (s2_data_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_prod_reg   <= s2_prod_next;
            s2_colofs_reg <= s2_colofs_next;
            s2_data_reg   <= s2_data_next;
            s2_bytes_reg  <= s1.bytes;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: final address sum, wrapping modulo 2^32, into the output
    // register that faces the receiver.
    // ------------------------------------------------------------------------
    assign out_addr_next = cfg_reg.buffer_base + 32'(s2_prod_reg) + 32'(s2_colofs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            out_addr_reg  <= out_addr_next;
            out_data_reg  <= s2_data_reg;
            out_bytes_reg <= s2_bytes_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_bytes_reg, out_data_reg, out_addr_reg};

endmodule

// ----- sv/rpwf_checker.sv -----
// ----------------------------------------------------------------------------
// rpwf_checker
// Port-level checks on the write stream of the rotated pixel write
// formatter, attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
module rpwf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // A write that is not taken stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("write withdrawn while stalled");

    // A stalled write keeps its contents.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("write changed while stalled");

    // Only 2, 3 or 4 byte writes are produced.
    a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[66:64] == 3'd2 || m_tdata[66:64] == 3'd3
                      || m_tdata[66:64] == 3'd4))
        else $error("illegal byte count");

    // Data bytes beyond the byte count are zero.
    a_data_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[66:64] != 3'd4 |-> m_tdata[63:56] == 8'd0
        && (m_tdata[66:64] != 3'd2 || m_tdata[55:48] == 8'd0))
        else $error("data bits above the byte count are set");

endmodule

bind rotated_pixel_write_formatter_core rpwf_checker u_rpwf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/rpwf_write_checker.sv -----
// ----------------------------------------------------------------------------
// rpwf_write_checker
// Passive scoreboard for the rotated pixel write formatter. It mirrors the
// configuration port, predicts the memory write for every pixel taken on
// the input stream and compares every write leaving the output stream with
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module rpwf_write_checker #(
    parameter int BIG_ENDIAN_HOST = rpwf_pkg::BIG_ENDIAN_HOST_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // s_tdata fields, low bit up: pos_x, pos_y, red, green, blue.
    input  logic [rpwf_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata fields, low bit up: write_address, write_data, byte_count.
    input  logic [rpwf_pkg::OUT_DATA_W-1:0] m_tdata,
    output int          fail_count,
    output int          pending_writes
);
    import rpwf_pkg::*;

    typedef struct {
        logic [31:0] address;
        logic [31:0] data;
        logic [2:0]  count;
    } pixel_write_t;

    cfg_t         shadow_cfg;
    pixel_write_t expected_writes[$];
    int           mismatches;

    // Keep the top bits of one 8-bit level (at most eight of them) and move
    // them to their bit offset in the 32-bit pixel word.
    function automatic logic [31:0] place_channel(input logic [7:0] level,
                                                  input logic [8:0] field);
        logic [3:0]  keep;
        logic [31:0] top_bits;
        keep = field[8:5];
        if (keep > 4'd8)
            keep = 4'd8;
        top_bits = {24'd0, level} >> (8 - keep);
        return top_bits << field[4:0];
    endfunction

    // Clip, rotate, address and pack one pixel. Returns 0 when the pixel
    // causes no memory write.
    function automatic bit predict_pixel_write(input cfg_t c,
                                               input logic [IN_DATA_W-1:0] pix,
                                               output pixel_write_t w);
        logic [15:0] x, y;
        logic [7:0]  red, green, blue, hi, lo;
        logic [31:0] col, row, wide_w, wide_h, word, swapped;
        logic [2:0]  nbytes;
        int          i;
        x      = pix[15:0];
        y      = pix[31:16];
        red    = pix[39:32];
        green  = pix[47:40];
        blue   = pix[55:48];
        w      = '{default: '0};
        wide_w = {20'd0, c.view_width};
        wide_h = {20'd0, c.view_height};
        if (c.pixel_depth == DEPTH_NONE)
            return 0;
        // Negative coordinates have the sign bit set and are always outside.
        if (x[15] || y[15] || x[14:0] >= c.view_width || y[14:0] >= c.view_height)
            return 0;
        case (c.rotation)
            ROT_90:  begin col = wide_h - y - 1; row = {16'd0, x}; end
            ROT_180: begin col = wide_w - x - 1; row = wide_h - y - 1; end
            ROT_270: begin col = {16'd0, y}; row = wide_w - x - 1; end
            default: begin col = {16'd0, x}; row = {16'd0, y}; end
        endcase
        case (c.pixel_depth)
            DEPTH_16: nbytes = BYTES_16;
            DEPTH_24: nbytes = BYTES_24;
            default:  nbytes = BYTES_32;
        endcase
        if (c.color_order >= ORDER_GENERIC) begin
            if (nbytes == BYTES_24)
                return 0;
            word = place_channel(red, c.channel_layout[8:0])
                 | place_channel(green, c.channel_layout[17:9])
                 | place_channel(blue, c.channel_layout[26:18]);
        end else begin
            hi = (c.color_order == ORDER_RGB) ? red : blue;
            lo = (c.color_order == ORDER_RGB) ? blue : red;
            if (nbytes == BYTES_16)
                word = {16'd0, hi[7:3], green[7:2], lo[7:3]};
            else if (nbytes == BYTES_24 && BIG_ENDIAN_HOST != 0)
                word = {8'd0, lo, green, hi};
            else
                word = {8'd0, hi, green, lo};
        end
        if (nbytes == BYTES_16)
            word = word & 32'h0000_FFFF;
        if (BIG_ENDIAN_HOST != 0 && nbytes != BYTES_24) begin
            swapped = '0;
            for (i = 0; i < nbytes; i++)
                swapped[8*(nbytes-1-i) +: 8] = word[8*i +: 8];
            word = swapped;
        end
        w.address = c.buffer_base + row * {16'd0, c.line_stride} + col * nbytes;
        w.data    = word;
        w.count   = nbytes;
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        pixel_write_t seen, oldest, predicted;
        if (!rst_n) begin
            shadow_cfg             = '0;
            shadow_cfg.pixel_depth = DEPTH_32;
            expected_writes.delete();
            mismatches             = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ROTATION:       shadow_cfg.rotation       = cfg_data[1:0];
                    CFG_COLOR_ORDER:    shadow_cfg.color_order    = cfg_data[1:0];
                    CFG_PIXEL_DEPTH:    shadow_cfg.pixel_depth    = cfg_data[1:0];
                    CFG_LINE_STRIDE:    shadow_cfg.line_stride    = cfg_data[15:0];
                    CFG_VIEW_WIDTH:     shadow_cfg.view_width     = cfg_data[11:0];
                    CFG_VIEW_HEIGHT:    shadow_cfg.view_height    = cfg_data[11:0];
                    CFG_CHANNEL_LAYOUT: shadow_cfg.channel_layout = cfg_data[26:0];
                    CFG_BUFFER_BASE:    shadow_cfg.buffer_base    = cfg_data;
                    default: ;
                endcase
            end
            // Outputs are checked before this edge's input is predicted, so a
            // write is never matched against a pixel taken in the same cycle.
            if (m_tvalid && m_tready) begin
                seen.address = m_tdata[31:0];
                seen.data    = m_tdata[63:32];
                seen.count   = m_tdata[66:64];
                if (expected_writes.size() == 0) begin
                    $error("unexpected write: address %h data %h byte_count %0d",
                           seen.address, seen.data, seen.count);
                    mismatches++;
                end else begin
                    oldest = expected_writes.pop_front();
                    if (seen.address !== oldest.address) begin
                        $error("write_address: expected %h, actual %h",
                               oldest.address, seen.address);
                        mismatches++;
                    end
                    if (seen.data !== oldest.data) begin
                        $error("write_data: expected %h, actual %h",
                               oldest.data, seen.data);
                        mismatches++;
                    end
                    if (seen.count !== oldest.count) begin
                        $error("byte_count: expected %0d, actual %0d",
                               oldest.count, seen.count);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (predict_pixel_write(shadow_cfg, s_tdata, predicted))
                    expected_writes.push_back(predicted);
            end
        end
        fail_count     <= mismatches;
        pending_writes <= expected_writes.size();
    end

endmodule

// ----- tb/rotated_pixel_write_formatter_core_tb.sv -----
// ----------------------------------------------------------------------------
// rotated_pixel_write_formatter_core_tb
// Drives pixels and register writes into the write formatter and gives the
// verdict. A directed pass covers view edges, every rotation, color order
// and depth, then random pixels run under a series of random setups while
// both stream sides throttle at varying rates.
// ----------------------------------------------------------------------------
module rotated_pixel_write_formatter_core_tb;
    import rpwf_pkg::*;

    localparam int HOST_ORDER   = BIG_ENDIAN_HOST_DEFAULT;
    localparam int SETUP_GROUPS = 15;
    localparam int GROUP_PIXELS = 30;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [2:0]            cfg_index;
    logic [31:0]           cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    int                    fail_count;
    int                    pending_writes;

    // Percentages of cycles in which the pixel source holds back and the
    // memory side refuses a transfer.
    int send_idle_pct;
    int recv_idle_pct;

    rotated_pixel_write_formatter_core #(
        .BIG_ENDIAN_HOST(HOST_ORDER)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rpwf_write_checker #(
        .BIG_ENDIAN_HOST(HOST_ORDER)
    ) write_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_writes(pending_writes)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Safety net: a run that hangs ends here with a failure.
    initial
    begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // The memory side accepts or refuses a transfer at random each cycle.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one pixel, possibly after a random gap, and return on the edge
    // at which the transfer takes place. tvalid stays high for a following
    // pixel with no gap, so back-to-back transfers keep the pipe full.
    task automatic send_pixel(input logic [15:0] x, input logic [15:0] y,
                              input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {blue, green, red, y, x};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stop offering pixels and wait until every predicted write has come
    // out. The edge before the loop lets the checker count the last
    // transfer; the tail lets dropped pixels leave the three-stage pipe
    // before any register changes.
    task automatic drain_writes();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_writes != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // One register write; the pipe must be empty when this is called.
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Two pixels near the first and the last column of the view under one rotation.
    task automatic directed_rotation(input logic [1:0] rot);
        drain_writes();
        write_reg(CFG_ROTATION, {30'd0, rot});
        send_pixel(16'd0, 16'd0, 8'hFF, 8'h00, 8'h80);
        send_pixel(16'd4094, 16'd7, 8'h01, 8'hFE, 8'h7F);
    endtask

    // Mostly positions inside the view, with its edges, the first position
    // past it, minus one and the full signed range mixed in.
    function automatic logic [15:0] pick_coord(input logic [11:0] extent);
        case ($urandom_range(11))
            0, 1:    return 16'($urandom);
            2:       return {4'd0, extent};
            3:       return 16'hFFFF;
            4:       return 16'd0;
            5:       return {4'd0, extent} - 16'd1;
            default: return (extent == 12'd0) ? 16'd0
                                              : 16'($urandom_range({20'd0, extent} - 1));
        endcase
    endfunction

    // A fresh random setup. Small views dominate so that most pixels land
    // inside; the extremes of every register turn up regularly.
    task automatic random_setup(output logic [11:0] w, output logic [11:0] h);
        logic [31:0] stride, base;
        case ($urandom_range(9))
            0:       w = 12'd4095;
            1:       w = 12'd0;
            2:       w = 12'd1;
            default: w = 12'($urandom_range(64, 2));
        endcase
        case ($urandom_range(9))
            0:       h = 12'd4095;
            1:       h = 12'd0;
            2:       h = 12'd1;
            default: h = 12'($urandom_range(64, 2));
        endcase
        case ($urandom_range(4))
            0:       stride = 32'd0;
            1:       stride = 32'd65535;
            default: stride = $urandom_range(65535);
        endcase
        case ($urandom_range(4))
            0:       base = 32'd0;
            1:       base = 32'hFFFF_FFFF;
            default: base = $urandom;
        endcase
        drain_writes();
        write_reg(CFG_ROTATION, $urandom_range(3));
        write_reg(CFG_COLOR_ORDER, $urandom_range(3));
        write_reg(CFG_PIXEL_DEPTH,
                  ($urandom_range(9) == 0) ? {30'd0, DEPTH_NONE} : $urandom_range(2));
        write_reg(CFG_LINE_STRIDE, stride);
        write_reg(CFG_VIEW_WIDTH, {20'd0, w});
        write_reg(CFG_VIEW_HEIGHT, {20'd0, h});
        write_reg(CFG_CHANNEL_LAYOUT, $urandom & 32'h07FF_FFFF);
        write_reg(CFG_BUFFER_BASE, base);
    endtask

    initial
    begin : stimulus
        logic [11:0] view_w, view_h;
        int          grp;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        send_idle_pct = 36;
        recv_idle_pct = 51;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset leaves an empty view, so this pixel must be dropped.
        send_pixel(16'd0, 16'd0, 8'hFF, 8'hFF, 8'hFF);

        // Largest view, stride and a base near the top of the address space
        // so that the address wraps.
        drain_writes();
        write_reg(CFG_VIEW_WIDTH, 32'd4095);
        write_reg(CFG_VIEW_HEIGHT, 32'd4095);
        write_reg(CFG_LINE_STRIDE, 32'd65535);
        write_reg(CFG_BUFFER_BASE, 32'hFFFF_FFF0);
        send_pixel(16'd0, 16'd0, 8'h00, 8'h00, 8'h00);
        send_pixel(16'd4094, 16'd4094, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(16'd4095, 16'd0, 8'h11, 8'h22, 8'h33);
        send_pixel(16'd0, 16'd4095, 8'h44, 8'h55, 8'h66);
        send_pixel(16'hFFFF, 16'd5, 8'h77, 8'h88, 8'h99);
        send_pixel(16'd5, 16'h8000, 8'hAA, 8'hBB, 8'hCC);
        send_pixel(16'h7FFF, 16'd0, 8'hDD, 8'hEE, 8'hF0);
        send_pixel(16'd100, 16'd200, 8'h12, 8'h34, 8'h56);

        directed_rotation(ROT_90);
        directed_rotation(ROT_180);
        directed_rotation(ROT_270);

        // BGR order at 16 and 24 bpp, then the unsupported depth.
        drain_writes();
        write_reg(CFG_ROTATION, {30'd0, ROT_0});
        write_reg(CFG_COLOR_ORDER, {30'd0, ORDER_BGR});
        write_reg(CFG_PIXEL_DEPTH, {30'd0, DEPTH_16});
        send_pixel(16'd3, 16'd9, 8'hF8, 8'hFC, 8'h07);
        drain_writes();
        write_reg(CFG_PIXEL_DEPTH, {30'd0, DEPTH_24});
        send_pixel(16'd4, 16'd9, 8'hA1, 8'hB2, 8'hC3);
        drain_writes();
        write_reg(CFG_PIXEL_DEPTH, {30'd0, DEPTH_NONE});
        send_pixel(16'd5, 16'd9, 8'hFF, 8'hFF, 8'hFF);

        // Generic layout: lengths above eight with the largest offsets,
        // zero lengths, the 24 bpp case that writes nothing, and color
        // order 3 at 16 bpp.
        drain_writes();
        write_reg(CFG_COLOR_ORDER, {30'd0, ORDER_GENERIC});
        write_reg(CFG_PIXEL_DEPTH, {30'd0, DEPTH_32});
        write_reg(CFG_CHANNEL_LAYOUT, 32'h07FF_FFFF);
        send_pixel(16'd6, 16'd9, 8'hFF, 8'h81, 8'h42);
        drain_writes();
        write_reg(CFG_CHANNEL_LAYOUT, 32'd0);
        send_pixel(16'd7, 16'd9, 8'hFF, 8'hFF, 8'hFF);
        drain_writes();
        write_reg(CFG_PIXEL_DEPTH, {30'd0, DEPTH_24});
        send_pixel(16'd8, 16'd9, 8'h5A, 8'hA5, 8'h3C);
        drain_writes();
        write_reg(CFG_COLOR_ORDER, 32'd3);
        write_reg(CFG_PIXEL_DEPTH, {30'd0, DEPTH_16});
        write_reg(CFG_CHANNEL_LAYOUT, {5'd0, 9'h0AB, 9'h0C5, 9'h0A0});
        send_pixel(16'd9, 16'd9, 8'hC3, 8'h3C, 8'hE7);

        // A view with no width drops even the origin.
        drain_writes();
        write_reg(CFG_VIEW_WIDTH, 32'd0);
        send_pixel(16'd0, 16'd0, 8'h10, 8'h20, 8'h30);

        // Random part: the first third with the sender idling less than the
        // receiver, then the reverse, then full rate on both sides.
        for (grp = 0; grp < SETUP_GROUPS; grp++) begin
            if (grp == SETUP_GROUPS / 3) begin
                send_idle_pct = 51;
                recv_idle_pct = 36;
            end else if (grp == 2 * SETUP_GROUPS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_setup(view_w, view_h);
            repeat (GROUP_PIXELS)
                send_pixel(pick_coord(view_w), pick_coord(view_h),
                           8'($urandom), 8'($urandom), 8'($urandom));
        end

        drain_writes();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_writes == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
